FILE: design/tacd_pkg.sv
// Shared types, constants and the segment table of the countdown display.
`default_nettype none

package tacd_pkg;

    localparam int LEVEL_W     = 12;
    localparam int SEQ_W       = 16;
    localparam int TIME_MS_W   = 14;
    localparam int TIMEOUT_W   = 16;
    localparam int DUTY_W      = 7;
    localparam int SEG_W       = 7;
    localparam int DIGITS      = 4;
    localparam int DIGIT_IDX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [LEVEL_W-1:0]   TRIGGER_RESET = 12'd4000;
    localparam logic [TIME_MS_W-1:0] LENGTH_RESET  = 14'd10000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd250;
    localparam logic [TIME_MS_W-1:0] LENGTH_MAX    = 14'd10000;
    localparam logic [LEVEL_W-1:0]   LEVEL_FULL    = 12'd4095;
    localparam logic [DUTY_W-1:0]    DUTY_FULL     = 7'd100;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_PACKET = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TRIGGER = 2'd0,
        REG_LENGTH  = 2'd1,
        REG_TIMEOUT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic               command;
        logic [LEVEL_W-1:0] pot_level;
        logic [SEQ_W-1:0]   packet_seq;
    } tacd_in_t;

    typedef struct packed {
        logic [SEG_W-1:0]     segment_bits;
        logic                 point_on;
        logic [DIGITS-1:0]    digit_enable_n;
        logic [DUTY_W-1:0]    led_duty;
        logic                 running;
        logic [TIME_MS_W-1:0] shown_time_ms;
        logic                 seq_gap;
        logic                 started;
        logic                 finished;
    } tacd_out_t;

    // Segment pattern of a decimal digit, bit 0 = A through bit 6 = G.
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] pattern;
        unique case (digit)
            4'd0:    pattern = 7'h3F;
            4'd1:    pattern = 7'h06;
            4'd2:    pattern = 7'h5B;
            4'd3:    pattern = 7'h4F;
            4'd4:    pattern = 7'h66;
            4'd5:    pattern = 7'h6D;
            4'd6:    pattern = 7'h7D;
            4'd7:    pattern = 7'h07;
            4'd8:    pattern = 7'h7F;
            4'd9:    pattern = 7'h6F;
            default: pattern = '0;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

FILE: design/tacd_in_if.sv
// Valid/ready channel that carries tick and packet items into the block.
`default_nettype none

interface tacd_in_if;
    import tacd_pkg::*;

    logic     valid;
    logic     ready;
    tacd_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/tacd_out_if.sv
// Valid/ready channel that carries display and status results out of the block.
`default_nettype none

interface tacd_out_if;
    import tacd_pkg::*;

    logic      valid;
    logic      ready;
    tacd_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/threshold_armed_countdown_display.sv
// An accepted transaction passes through stage 1 and then the output register.
// Throughput: one item per cycle unless the output stalls; state update and
// digit decode are two register stages, each one short combinational step.
// Reset: asynchronous, active low; countdown armed, display at full time,
// segments off and all digits disabled, registers at their default values.
`default_nettype none

module threshold_armed_countdown_display
    import tacd_pkg::*;
#(
    parameter int TIMESTAMP_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    tacd_in_if.sink                item,
    tacd_out_if.source             result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef struct packed {
        logic                   tick;
        logic [DIGIT_IDX_W-1:0] idx;
        logic [TIME_MS_W-1:0]   shown;
        logic [DUTY_W-1:0]      duty;
        logic                   running;
        logic                   gap;
        logic                   started;
        logic                   finished;
    } stage_t;

    // Configuration registers
    logic [LEVEL_W-1:0]   trigger_reg;
    logic [TIME_MS_W-1:0] length_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Countdown state
    logic [TIMESTAMP_BITS-1:0] time_reg, time_next;
    logic [TIMESTAMP_BITS-1:0] last_packet_reg, last_packet_next;
    logic [TIMESTAMP_BITS-1:0] start_reg, start_next;
    logic [SEQ_W-1:0]          prev_seq_reg, prev_seq_next;
    logic                      active_reg, active_next;
    logic                      armed_reg, armed_next;
    logic [TIME_MS_W-1:0]      display_reg, display_next;
    logic [DIGIT_IDX_W-1:0]    digit_idx_reg, digit_idx_next;
    logic [DUTY_W-1:0]         duty_reg, duty_next;

    // Pipeline
    logic      s1_valid_reg;
    stage_t    s1_reg, s1_next;
    logic      out_valid_reg;
    tacd_out_t out_reg, out_next;

    logic adv_out;
    logic s1_free;
    logic accept;

    logic [TIME_MS_W-1:0]      eff_len;
    logic [TIMESTAMP_BITS-1:0] tick_time;
    logic [TIMESTAMP_BITS-1:0] elapsed;
    logic [TIMESTAMP_BITS-1:0] silence;
    logic                      is_packet;
    logic                      level_low;

    logic [LEVEL_W+6:0]   duty_prod;
    logic [DUTY_W-1:0]    duty_q0;
    logic [LEVEL_W:0]     duty_rem;
    logic [DUTY_W-1:0]    duty_calc;

    logic [29:0]          prod10;
    logic [26:0]          prod100;
    logic [27:0]          prod1000;
    logic [10:0]          q10;
    logic [7:0]           q100;
    logic [4:0]           q1000;
    logic                 q10000;
    logic [10:0]          rem3;
    logic [7:0]           rem2;
    logic [4:0]           rem1;
    logic [3:0]           digit;
    logic                 point;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign adv_out      = !out_valid_reg || result.ready;
    assign s1_free      = !s1_valid_reg || adv_out;
    assign accept       = item.valid && s1_free;
    assign item.ready   = s1_free;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg <= TRIGGER_RESET;
            length_reg  <= LENGTH_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TRIGGER: trigger_reg <= cfg_data[LEVEL_W-1:0];
                REG_LENGTH:  length_reg  <= cfg_data[TIME_MS_W-1:0];
                REG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                default:     ;
            endcase
        end
    end

    assign eff_len = (length_reg > LENGTH_MAX) ? LENGTH_MAX : length_reg;

    // ------------------------------------------------------------------
    // State update at acceptance
    // ------------------------------------------------------------------
    // level * 100 / 4095: since 4095 = 4096 - 1, the quotient of the product
    // by 4096 is at most one short, and the remainder stays below 2 * 4095.
    assign duty_prod = {1'b0, item.data.pot_level, 6'd0}
                     + {2'b0, item.data.pot_level, 5'd0}
                     + {5'b0, item.data.pot_level, 2'd0};
    assign duty_q0   = duty_prod[LEVEL_W+6:LEVEL_W];
    assign duty_rem  = {1'b0, duty_prod[LEVEL_W-1:0]} + {{(LEVEL_W+1-DUTY_W){1'b0}}, duty_q0};
    assign duty_calc = duty_q0 + DUTY_W'(duty_rem >= {1'b0, LEVEL_FULL});

    assign is_packet = (item.data.command == CMD_PACKET);
    assign level_low = (item.data.pot_level < trigger_reg);
    assign tick_time = time_reg + 1'b1;
    assign elapsed   = tick_time - start_reg;
    assign silence   = tick_time - last_packet_reg;

    always_comb
    begin
        time_next        = time_reg;
        last_packet_next = last_packet_reg;
        start_next       = start_reg;
        prev_seq_next    = prev_seq_reg;
        active_next      = active_reg;
        armed_next       = armed_reg;
        display_next     = display_reg;
        digit_idx_next   = digit_idx_reg;
        duty_next        = duty_reg;
        s1_next          = '0;

        if (is_packet)
        begin
            last_packet_next = time_reg;
            duty_next        = duty_calc;
            prev_seq_next    = item.data.packet_seq;
            s1_next.gap      = ((prev_seq_reg + 1'b1) != item.data.packet_seq);
            if (level_low)
            begin
                if (!active_reg)
                begin
                    armed_next   = 1'b1;
                    display_next = eff_len;
                end
            end
            else if (armed_reg && !active_reg)
            begin
                armed_next      = 1'b0;
                active_next     = 1'b1;
                start_next      = time_reg;
                display_next    = eff_len;
                s1_next.started = 1'b1;
            end
        end
        else
        begin
            time_next = tick_time;
            if (active_reg)
            begin
                if (elapsed >= TIMESTAMP_BITS'(eff_len))
                begin
                    active_next      = 1'b0;
                    display_next     = '0;
                    s1_next.finished = 1'b1;
                end
                else
                begin
                    display_next = eff_len - elapsed[TIME_MS_W-1:0];
                end
            end
            digit_idx_next = digit_idx_reg + 1'b1;
            if (silence > TIMESTAMP_BITS'(timeout_reg))
            begin
                duty_next = '0;
            end
        end

        s1_next.tick    = !is_packet;
        s1_next.idx     = digit_idx_reg;
        s1_next.shown   = (display_next > eff_len) ? eff_len : display_next;
        s1_next.duty    = duty_next;
        s1_next.running = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg        <= '0;
            last_packet_reg <= '0;
            start_reg       <= '0;
            prev_seq_reg    <= '0;
            active_reg      <= 1'b0;
            armed_reg       <= 1'b1;
            display_reg     <= LENGTH_MAX;
            digit_idx_reg   <= '0;
            duty_reg        <= '0;
        end
        else if (accept)
        begin
            time_reg        <= time_next;
            last_packet_reg <= last_packet_next;
            start_reg       <= start_next;
            prev_seq_reg    <= prev_seq_next;
            active_reg      <= active_next;
            armed_reg       <= armed_next;
            display_reg     <= display_next;
            digit_idx_reg   <= digit_idx_next;
            duty_reg        <= duty_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Digit decode: shown time as XX.XX seconds, one digit per tick
    // ------------------------------------------------------------------
    // Reciprocal multiplications, exact for every 14-bit value.
    assign prod10   = 30'(s1_reg.shown) * 30'd52429;
    assign prod100  = 27'(s1_reg.shown) * 27'd5243;
    assign prod1000 = 28'(s1_reg.shown) * 28'd8389;
    assign q10      = prod10[29:19];
    assign q100     = prod100[26:19];
    assign q1000    = prod1000[27:23];
    assign q10000   = (s1_reg.shown >= LENGTH_MAX);

    assign rem3 = q10 - ({q100, 3'd0} + {2'd0, q100, 1'b0});
    assign rem2 = q100 - ({q1000, 3'd0} + {2'd0, q1000, 1'b0});
    assign rem1 = q1000 - ({1'b0, q10000, 3'd0} + {3'd0, q10000, 1'b0});

    always_comb
    begin
        point = 1'b0;
        unique case (s1_reg.idx)
            2'd0:
            begin
                digit = {3'd0, q10000};
            end
            2'd1:
            begin
                digit = rem1[3:0];
                point = 1'b1;
            end
            2'd2:    digit = rem2[3:0];
            default: digit = rem3[3:0];
        endcase
    end

    always_comb
    begin
        out_next = out_reg;
        if (s1_reg.tick)
        begin
            out_next.segment_bits   = seg_pattern(digit);
            out_next.point_on       = point;
            out_next.digit_enable_n = ~(DIGITS'(1) << s1_reg.idx);
        end
        out_next.led_duty      = s1_reg.duty;
        out_next.running       = s1_reg.running;
        out_next.shown_time_ms = s1_reg.shown;
        out_next.seq_gap       = s1_reg.gap;
        out_next.started       = s1_reg.started;
        out_next.finished      = s1_reg.finished;
    end

    // The segment fields double as the latched display, so they reset too.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '{digit_enable_n: '1, default: '0};
        end
        else
        begin
            if (adv_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (adv_out && s1_valid_reg)
            begin
                out_reg <= out_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.data.command == CMD_TICK) |=> time_reg == $past(time_reg) + 1'b1)
        else $error("millisecond counter did not advance on a tick");

    a_shown_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.data.shown_time_ms <= eff_len)
        else $error("shown time exceeds the countdown length");

    a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> $countones(result.data.digit_enable_n) >= DIGITS - 1)
        else $error("more than one digit enabled");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.started) |->
            (result.data.running && !result.data.finished))
        else $error("started transaction does not report a running countdown");
`endif

endmodule

`default_nettype wire
